// ----- rtl/region_current_lookup_unit_assert.svh -----
// Assertion macros for the region current lookup controller
`ifndef REGION_CURRENT_LOOKUP_UNIT_ASSERT_SVH
`define REGION_CURRENT_LOOKUP_UNIT_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define RCL_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define RCL_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- rtl/rcl_pkg.sv -----
// Package: types, constants and tables of the region current lookup unit
`timescale 1ns / 1ps
`default_nettype none
package rcl_pkg;
	localparam int MAX_REGIONS = 16;
	localparam int RW = $clog2(MAX_REGIONS);
	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam logic [1:0] FUNC_APPEND = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_POS = 2'd2;
	localparam logic [1:0] REG_DEPTH = 2'd0;
	localparam logic [1:0] REG_PERIODIC = 2'd1;
	localparam logic [1:0] REG_REPUB = 2'd2;
	localparam logic [31:0] FIRST_DEADLINE = 32'd10000;
	localparam logic [31:0] STEP_DEADLINE = 32'd5000;
	localparam int TAB_W = 180;
	localparam int VEC_W = 48;
	localparam int ANG_W = 6;
	localparam logic [ANG_W-1:0] ANG_LAST = 6'd35;
	localparam logic [ANG_W-1:0] ANG_QUARTER = 6'd27;

	// commands from controller to datapath
	typedef struct packed {
		logic latch;      // capture the input item
		logic append;     // write region at fill count
		logic rd;         // read table entry at rd_idx
		logic [RW-1:0] rd_idx;
		logic test;       // evaluate containment of read entry
		logic take;       // commit read entry as the found region
		logic finish;     // compute vector and emit decision
		logic publish;    // load output register
	} cmd_t;

	typedef struct packed {
		logic hit;        // entry just tested holds the point
		logic emit;       // result should be emitted
	} sts_t;

	function automatic logic signed [15:0] cos_q8(input logic [ANG_W-1:0] a);
		logic signed [15:0] v;
		unique case (a)
			6'd0: v = 256; 6'd1: v = 252; 6'd2: v = 241; 6'd3: v = 222;
			6'd4: v = 196; 6'd5: v = 165; 6'd6: v = 128; 6'd7: v = 88;
			6'd8: v = 44; 6'd9: v = 0; 6'd10: v = -44; 6'd11: v = -88;
			6'd12: v = -128; 6'd13: v = -165; 6'd14: v = -196; 6'd15: v = -222;
			6'd16: v = -241; 6'd17: v = -252; 6'd18: v = -256; 6'd19: v = -252;
			6'd20: v = -241; 6'd21: v = -222; 6'd22: v = -196; 6'd23: v = -165;
			6'd24: v = -128; 6'd25: v = -88; 6'd26: v = -44; 6'd27: v = 0;
			6'd28: v = 44; 6'd29: v = 88; 6'd30: v = 128; 6'd31: v = 165;
			6'd32: v = 196; 6'd33: v = 222; 6'd34: v = 241; 6'd35: v = 252;
			default: v = 0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/rcl_ram.sv -----
// Generic RAM with one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module rcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/rcl_datapath.sv -----
// Datapath: region tables, containment test, vector and output register
`timescale 1ns / 1ps
`default_nettype none
module rcl_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rcl_pkg::cmd_t       cmd,
	output rcl_pkg::sts_t            sts,
	input  wire logic [303:0]        in_data,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_idx,
	input  wire logic [31:0]         cfg_val,
	input  wire logic [rcl_pkg::RW-1:0] wr_idx,
	output logic [100:0]             out_data
);
	logic [303:0] item_q;
	logic signed [31:0] depth_limit_q;
	logic periodic_q;
	logic [15:0] repub_q;
	logic [rcl_pkg::RW-1:0] reg_q;
	logic found_q;
	logic [rcl_pkg::VEC_W-1:0] last_vec_q, vec_q;
	logic emitted_q;
	logic [31:0] repub_at_q;
	logic emit_q;
	logic [rcl_pkg::ANG_W-1:0] angle_q [rcl_pkg::MAX_REGIONS];
	logic [31:0] deadline_q [rcl_pkg::MAX_REGIONS];
	logic [127:0] bounds_rd;
	logic [rcl_pkg::VEC_W-1:0] vec_rd;
	logic hit_q;

	wire signed [31:0] top_n = item_q[31:0];
	wire signed [31:0] top_e = item_q[63:32];
	wire signed [31:0] bot_n = item_q[95:64];
	wire signed [31:0] bot_e = item_q[127:96];
	wire [47:0] cur = item_q[175:128];
	wire signed [31:0] pn = item_q[207:176];
	wire signed [31:0] pe = item_q[239:208];
	wire signed [31:0] pd = item_q[271:240];
	wire [31:0] now = item_q[303:272];

	rcl_ram #(.WIDTH(128), .DEPTH(rcl_pkg::MAX_REGIONS)) u_bounds (
		.clk(clk), .we(cmd.append), .waddr(wr_idx),
		.wdata({bot_e, bot_n, top_e, top_n}), .raddr(cmd.rd_idx), .rdata(bounds_rd));
	rcl_ram #(.WIDTH(rcl_pkg::VEC_W), .DEPTH(rcl_pkg::MAX_REGIONS)) u_vec (
		.clk(clk), .we(cmd.append), .waddr(wr_idx), .wdata(cur),
		.raddr(cmd.rd_idx), .rdata(vec_rd));

	wire signed [31:0] r_tn = bounds_rd[31:0];
	wire signed [31:0] r_te = bounds_rd[63:32];
	wire signed [31:0] r_bn = bounds_rd[95:64];
	wire signed [31:0] r_be = bounds_rd[127:96];

	// index of the region read last, held for the take command
	logic [rcl_pkg::RW-1:0] rd_idx_q;
	always_ff @(posedge clk) begin
		if (cmd.rd) rd_idx_q <= cmd.rd_idx;
		if (cmd.test) hit_q <= pe > r_te && pe <= r_be && pn <= r_tn && pn > r_bn;
	end
	assign sts.hit = hit_q;
	assign sts.emit = emit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_limit_q <= 32'sd128;
			periodic_q <= 1'b0;
			repub_q <= 16'd200;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				rcl_pkg::REG_DEPTH: depth_limit_q <= cfg_val;
				rcl_pkg::REG_PERIODIC: periodic_q <= cfg_val[0];
				rcl_pkg::REG_REPUB: repub_q <= cfg_val[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) item_q <= in_data;
	end

	logic [rcl_pkg::ANG_W-1:0] ang_cur, ang_new;
	logic [rcl_pkg::ANG_W-1:0] ang_q90;
	logic step;
	logic [rcl_pkg::VEC_W-1:0] vec_new;
	always_comb begin
		ang_cur = angle_q[reg_q];
		step = found_q && periodic_q && now >= deadline_q[reg_q];
		ang_new = step ? ((ang_cur == rcl_pkg::ANG_LAST) ? '0 : ang_cur + 1'b1) : ang_cur;
		ang_q90 = (ang_new >= 6'd9) ? ang_new - 6'd9 : ang_new + rcl_pkg::ANG_QUARTER;
		if (!found_q) vec_new = '0;
		else if (periodic_q)
			vec_new = {16'd0, rcl_pkg::cos_q8(ang_q90), rcl_pkg::cos_q8(ang_new)};
		else vec_new = vec_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			reg_q <= '0;
			last_vec_q <= '0;
			vec_q <= '0;
			emitted_q <= 1'b0;
			repub_at_q <= '0;
			emit_q <= 1'b0;
		end else begin
			if (cmd.latch) begin
				found_q <= 1'b0;
				reg_q <= '0;
			end
			if (cmd.take) begin
				found_q <= 1'b1;
				reg_q <= rd_idx_q;
			end
			if (cmd.finish) begin
				vec_q <= vec_new;
				emit_q <= vec_new != last_vec_q || !emitted_q || now >= repub_at_q;
				if (vec_new != last_vec_q || !emitted_q || now >= repub_at_q) begin
					last_vec_q <= vec_new;
					emitted_q <= 1'b1;
					repub_at_q <= now + {16'd0, repub_q};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < rcl_pkg::MAX_REGIONS; i++) begin
			if (cmd.append && wr_idx == i[rcl_pkg::RW-1:0]) begin
				angle_q[i] <= '0;
				deadline_q[i] <= now + rcl_pkg::FIRST_DEADLINE;
			end else if (cmd.finish && step && reg_q == i[rcl_pkg::RW-1:0]) begin
				angle_q[i] <= ang_new;
				deadline_q[i] <= deadline_q[i] + rcl_pkg::STEP_DEADLINE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_data[47:0] <= vec_q;
			out_data[95:48] <= (pd <= depth_limit_q) ? vec_q : '0;
			out_data[100:96] <= {found_q, reg_q};
		end
	end
endmodule
`default_nettype wire

// ----- rtl/rcl_ctrl.sv -----
// Controller: sequencing of appends, region scan and result hand-off
`timescale 1ns / 1ps
`default_nettype none
`include "region_current_lookup_unit_assert.svh"
module rcl_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_fire,
	input  wire logic [1:0]    in_func,
	input  wire logic          out_taken,
	input  wire rcl_pkg::sts_t sts,
	output rcl_pkg::cmd_t      cmd,
	output logic [rcl_pkg::RW-1:0] wr_idx,
	output logic               in_ready,
	output logic               out_valid
);
	localparam logic [2:0] S_IDLE = 3'd0, S_LAST = 3'd1, S_LTEST = 3'd2, S_SCAN = 3'd3;
	localparam logic [2:0] S_TEST = 3'd4, S_FIN = 3'd5, S_PUB = 3'd6, S_DEC = 3'd7;
	logic [2:0] state_q;
	logic [rcl_pkg::CW-1:0] held_q;
	logic [rcl_pkg::CW-1:0] idx_q;
	logic en_q, have_q;
	logic [rcl_pkg::RW-1:0] last_q;
	logic [1:0] func_q;
	// hit is registered, so decide in the cycle after the test
	logic pend_q;
	// set while the remembered region is being checked
	logic last_chk_q;
	logic pub_go;

	assign wr_idx = held_q[rcl_pkg::RW-1:0];
	assign in_ready = state_q == S_IDLE;
	// load the output register once the previous result has gone or goes now
	assign pub_go = state_q == S_PUB && sts.emit && (!out_valid || out_taken);

	always_comb begin
		cmd = '0;
		cmd.latch = in_fire;
		cmd.append = state_q == S_DEC && func_q == rcl_pkg::FUNC_APPEND
			&& held_q < rcl_pkg::CW'(rcl_pkg::MAX_REGIONS);
		cmd.rd_idx = idx_q[rcl_pkg::RW-1:0];
		cmd.rd = state_q == S_LAST || state_q == S_SCAN;
		cmd.test = state_q == S_LTEST || state_q == S_TEST;
		cmd.take = state_q == S_TEST && pend_q && sts.hit;
		cmd.finish = state_q == S_FIN;
		cmd.publish = pub_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			held_q <= '0;
			idx_q <= '0;
			en_q <= 1'b0;
			have_q <= 1'b0;
			last_q <= '0;
			func_q <= '0;
			out_valid <= 1'b0;
			pend_q <= 1'b0;
			last_chk_q <= 1'b0;
		end else begin
			if (pub_go) out_valid <= 1'b1;
			else if (out_taken) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					func_q <= in_func;
					state_q <= S_DEC;
				end
				S_DEC: begin
					state_q <= S_IDLE;
					if (func_q == rcl_pkg::FUNC_APPEND) begin
						if (cmd.append) held_q <= held_q + 1'b1;
					end else if (func_q == rcl_pkg::FUNC_START) en_q <= 1'b1;
					else if (func_q == rcl_pkg::FUNC_POS && en_q) begin
						if (have_q && {1'b0, last_q} < held_q) begin
							idx_q <= rcl_pkg::CW'(last_q);
							last_chk_q <= 1'b1;
							state_q <= S_LAST;
						end else if (held_q == '0) begin
							have_q <= 1'b0;
							last_q <= '0;
							state_q <= S_FIN;
						end else begin
							idx_q <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_LAST: state_q <= S_LTEST;
				S_LTEST: begin
					pend_q <= 1'b1;
					state_q <= S_TEST;
				end
				S_SCAN: state_q <= S_TEST;
				S_TEST: begin
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						last_chk_q <= 1'b0;
						if (sts.hit) begin
							have_q <= 1'b1;
							last_q <= idx_q[rcl_pkg::RW-1:0];
							state_q <= S_FIN;
						end else if (last_chk_q) begin
							// remembered region missed: scan the table from the start
							idx_q <= '0;
							state_q <= S_SCAN;
						end else if (idx_q + 1'b1 >= held_q) begin
							// a miss ends with no region remembered
							have_q <= 1'b0;
							last_q <= '0;
							state_q <= S_FIN;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_FIN: state_q <= S_PUB;
				S_PUB: if (!sts.emit || pub_go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RCL_ASSERT_IMP(a_no_accept_busy, in_fire, state_q == S_IDLE)
	`RCL_ASSERT_IMP(a_held_bound, 1'b1, held_q <= rcl_pkg::CW'(rcl_pkg::MAX_REGIONS))
	`RCL_ASSERT_NXT(a_pub_valid, state_q == S_PUB && sts.emit, out_valid)
endmodule
`default_nettype wire

// ----- rtl/region_current_lookup_unit.sv -----
// Top level of the region current lookup unit
//
// Input stream s_axis: one item per transfer; func in tuser, fields in tdata.
// func 0 appends a region (ignored when the table is full), func 1 enables
// lookups, func 2 looks up a position. Only position items give a result,
// on m_axis, and only when the vector changed, on the first result, or when
// the republish time has been reached.
// Handling: s_axis_tready is high only while idle, so each item is finished
// before the next is accepted. A lookup checks the remembered region first,
// when one is held, then scans the table from region 0; each region takes a
// registered table read, a registered containment test and the decision.
// A result waits in the output register; the next item is still accepted and
// processed, and holds before its own result until that register is taken,
// so a stalled receiver stalls s_axis one item later.
// Configuration writes via cfg_valid/cfg_ready with cfg_index and cfg_data:
// 0 depth limit, 1 periodic mode, 2 republish interval.
// Reset clears the fill count, lookups enable, remembered region and vector;
// registers return to 128, 0 and 200. Table contents are undefined until
// written.
`timescale 1ns / 1ps
`default_nettype none
module region_current_lookup_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// top_north, top_east, bottom_north, bottom_east, cur_north, cur_east, cur_down,
	// pos_north, pos_east, pos_depth, now_ms
	input  wire logic [303:0] s_axis_tdata,
	// func
	input  wire logic [1:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// sensor_north, sensor_east, sensor_down, act_north, act_east, act_down
	output logic [95:0]       m_axis_tdata,
	// in_region, region_number
	output logic [4:0]        m_axis_tuser,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	rcl_pkg::cmd_t cmd;
	rcl_pkg::sts_t sts;
	logic [rcl_pkg::RW-1:0] wr_idx;
	logic [100:0] out_data;
	wire in_fire = s_axis_tvalid && s_axis_tready;

	assign cfg_ready = 1'b1;

	rcl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_func(s_axis_tuser),
		.out_taken(m_axis_tvalid && m_axis_tready), .sts(sts), .cmd(cmd),
		.wr_idx(wr_idx), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid));

	rcl_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_data(s_axis_tdata), .cfg_we(cfg_valid),
		.cfg_idx(cfg_index), .cfg_val(cfg_data), .wr_idx(wr_idx), .out_data(out_data));

	assign m_axis_tdata = out_data[95:0];
	assign m_axis_tuser = {out_data[99:96], out_data[100]};
endmodule
`default_nettype wire

// ----- tb/region_current_lookup_checker.sv -----
// Checker: watches the streams and the register channel, predicts lookups and compares results
`timescale 1ns / 1ps
module region_current_lookup_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [303:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [95:0]  m_tdata,
	input  logic [4:0]   m_tuser,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           errors,
	output int           pending
);
	localparam logic signed [15:0] UNIT_Q8 [36] = '{
		256, 252, 241, 222, 196, 165, 128, 88, 44,
		0, -44, -88, -128, -165, -196, -222, -241, -252,
		-256, -252, -241, -222, -196, -165, -128, -88, -44,
		0, 44, 88, 128, 165, 196, 222, 241, 252
	};

	// vectors: sensor n/e/d then act n/e/d, 16 bits each from the lowest; tag: {in_region, region}
	typedef struct packed {
		logic [95:0] vecs;
		logic [4:0]  tag;
	} current_t;

	current_t sensed_q[$];

	logic signed [31:0] r_ntop [rcl_pkg::MAX_REGIONS];
	logic signed [31:0] r_nbot [rcl_pkg::MAX_REGIONS];
	logic signed [31:0] r_etop [rcl_pkg::MAX_REGIONS];
	logic signed [31:0] r_ebot [rcl_pkg::MAX_REGIONS];
	logic signed [15:0] r_vec [rcl_pkg::MAX_REGIONS][3];
	logic [5:0]         r_ang [rcl_pkg::MAX_REGIONS];
	logic [31:0]        r_due [rcl_pkg::MAX_REGIONS];
	int                 held;
	bit                 enabled, have_last, emitted;
	logic [3:0]         last_idx;
	logic signed [15:0] last_vec [3];
	logic [31:0]        repub_at;

	logic signed [31:0] depth_lim;
	bit                 rotating;
	logic [15:0]        repub_ms;

	function automatic bit holds_point(int r, logic signed [31:0] n, logic signed [31:0] e);
		return e > r_etop[r] && e <= r_ebot[r] && n <= r_ntop[r] && n > r_nbot[r];
	endfunction

	task automatic predict_current(input logic [303:0] d, input logic [1:0] f);
		logic signed [31:0] n, e, dep;
		logic [31:0] now;
		logic signed [15:0] v [3];
		bit found, fire;
		int r, i, a;
		current_t c;
		now = d[303:272];
		if (f == rcl_pkg::FUNC_APPEND) begin
			if (held < rcl_pkg::MAX_REGIONS) begin
				r_ntop[held] = d[31:0];
				r_etop[held] = d[63:32];
				r_nbot[held] = d[95:64];
				r_ebot[held] = d[127:96];
				r_vec[held][0] = d[143:128];
				r_vec[held][1] = d[159:144];
				r_vec[held][2] = d[175:160];
				r_ang[held] = 0;
				r_due[held] = now + rcl_pkg::FIRST_DEADLINE;
				held++;
			end
		end else if (f == rcl_pkg::FUNC_START) begin
			enabled = 1;
		end else if (f == rcl_pkg::FUNC_POS && enabled) begin
			n = d[207:176];
			e = d[239:208];
			dep = d[271:240];
			found = 0;
			r = 0;
			if (have_last && int'(last_idx) < held && holds_point(int'(last_idx), n, e)) begin
				found = 1;
				r = int'(last_idx);
			end
			for (i = 0; i < held && !found; i++)
				if (holds_point(i, n, e)) begin
					found = 1;
					r = i;
				end
			have_last = found;
			last_idx = found ? r[3:0] : 4'd0;
			v[0] = 0; v[1] = 0; v[2] = 0;
			if (found) begin
				if (rotating) begin
					if (now >= r_due[r]) begin
						r_ang[r] = (r_ang[r] == rcl_pkg::ANG_LAST) ? 6'd0 : r_ang[r] + 6'd1;
						r_due[r] = r_due[r] + rcl_pkg::STEP_DEADLINE;
					end
					a = int'(r_ang[r]);
					v[0] = UNIT_Q8[a];
					v[1] = UNIT_Q8[(a + 27) % 36];
				end else begin
					v[0] = r_vec[r][0]; v[1] = r_vec[r][1]; v[2] = r_vec[r][2];
				end
			end
			fire = v[0] != last_vec[0] || v[1] != last_vec[1] || v[2] != last_vec[2] ||
				!emitted || now >= repub_at;
			if (fire) begin
				last_vec = v;
				repub_at = now + {16'd0, repub_ms};
				emitted = 1;
				for (i = 0; i < 3; i++) begin
					c.vecs[16*i +: 16] = v[i];
					c.vecs[48 + 16*i +: 16] = (dep <= depth_lim) ? v[i] : 16'sd0;
				end
				c.tag = {found, found ? r[3:0] : 4'd0};
				sensed_q = {sensed_q, c};
			end
		end
	endtask

	task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
		errors++;
		if (errors <= 10)
			$display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin : watch
		current_t want;
		int k;
		if (!arst_n) begin
			sensed_q.delete();
			held = 0;
			enabled = 0;
			have_last = 0;
			emitted = 0;
			last_idx = 0;
			last_vec[0] = 0; last_vec[1] = 0; last_vec[2] = 0;
			repub_at = 0;
			depth_lim = 128;
			rotating = 0;
			repub_ms = 200;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == rcl_pkg::REG_DEPTH) depth_lim = cfg_data;
				else if (cfg_index == rcl_pkg::REG_PERIODIC) rotating = cfg_data[0];
				else if (cfg_index == rcl_pkg::REG_REPUB) repub_ms = cfg_data[15:0];
			end
			if (s_tvalid && s_tready)
				predict_current(s_tdata, s_tuser);
			if (m_tvalid && m_tready) begin
				if (sensed_q.size() == 0) begin
					report("unexpected result", 16'd0, m_tdata[15:0]);
				end else begin
					want = sensed_q.pop_front();
					for (k = 0; k < 6; k++)
						if (want.vecs[16*k +: 16] !== m_tdata[16*k +: 16])
							report($sformatf("vector field %0d", k),
								want.vecs[16*k +: 16], m_tdata[16*k +: 16]);
					if (want.tag[3:0] !== m_tuser[4:1])
						report("region_number", {12'd0, want.tag[3:0]}, {12'd0, m_tuser[4:1]});
					if (want.tag[4] !== m_tuser[0])
						report("in_region", {15'd0, want.tag[4]}, {15'd0, m_tuser[0]});
				end
			end
			pending = sensed_q.size();
		end
	end
endmodule

// ----- tb/region_current_lookup_unit_test.sv -----
// Testbench top: drives regions, starts, positions and register writes into the lookup unit
`timescale 1ns / 1ps
module region_current_lookup_unit_test;
	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int PHASE_ITEMS = 255;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [303:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [95:0]  m_axis_tdata;
	logic [4:0]   m_axis_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;
	int           errors, pending;

	region_current_lookup_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	region_current_lookup_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
		.s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
		.m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
		.m_tdata(m_axis_tdata), .m_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: own stall pattern, plus a long hold-off on request
	int hold_ask = 0, hold_seen = 0, hold_left = 0, rx_tick = 0, rx_mode = 0;
	always @(negedge clk) begin
		rx_tick++;
		if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_seen != hold_ask) begin
			hold_seen = hold_ask;
			hold_left = 400;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= rx_tick[2];
			endcase
		end
	end

	// copy of the regions sent, for aiming positions inside them
	int          held = 0;
	int          aim_te [rcl_pkg::MAX_REGIONS], aim_be [rcl_pkg::MAX_REGIONS];
	int          aim_bn [rcl_pkg::MAX_REGIONS], aim_tn [rcl_pkg::MAX_REGIONS];
	logic [31:0] now_ms = 0;
	int          depth_now = 128;
	int          burst_left = 0;

	// caller stands at a falling edge; returns at the falling edge after the transfer
	task automatic send(input logic [1:0] f, input logic [303:0] d);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= f;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic append(input int tn, te, bn, be, input logic [15:0] cn, ce, cd);
		logic [303:0] d;
		d = '0;
		d[31:0] = tn; d[63:32] = te; d[95:64] = bn; d[127:96] = be;
		d[143:128] = cn; d[159:144] = ce; d[175:160] = cd;
		d[303:272] = now_ms;
		if (held < rcl_pkg::MAX_REGIONS) begin
			aim_tn[held] = tn; aim_te[held] = te; aim_bn[held] = bn; aim_be[held] = be;
			held++;
		end
		send(rcl_pkg::FUNC_APPEND, d);
	endtask

	task automatic position(input int n, e, dep);
		logic [303:0] d;
		d = '0;
		d[207:176] = n; d[239:208] = e; d[271:240] = dep;
		d[303:272] = now_ms;
		send(rcl_pkg::FUNC_POS, d);
	endtask

	task automatic plain(input logic [1:0] f);
		logic [303:0] d;
		d = '0;
		d[303:272] = now_ms;
		send(f, d);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// drop valid and wait for the last result and the tail of any lookup
	task automatic settle;
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		burst_left = 0;
	endtask

	function automatic int coord_inside(input int lo, hi);
		longint span;
		span = longint'(hi) - longint'(lo);
		if (span <= 0) return $urandom;
		return int'(longint'(lo) + 1 + longint'($urandom) % span);
	endfunction

	task automatic random_item;
		logic [303:0] d;
		int pick, r, n, e, dep, w;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) == 0) now_ms = $urandom;
		else now_ms = now_ms + $urandom_range(0, 400);
		if (pick < 6) begin
			if ($urandom_range(0, 9) == 0) begin
				append($urandom, $urandom, $urandom, $urandom,
					16'($urandom), 16'($urandom), 16'($urandom));
			end else begin
				e = int'($urandom_range(0, 20000)) - 10000;
				n = int'($urandom_range(0, 20000)) - 10000;
				w = $urandom_range(1, 8000);
				append(n + w, e, n, e + int'($urandom_range(1, 8000)),
					16'($urandom), 16'($urandom), 16'($urandom));
			end
		end else if (pick < 12) begin
			for (int k = 0; k < 9; k++) d[32*k +: 32] = $urandom;
			d[303:288] = 16'($urandom);
			send(2'($urandom_range(0, 3)), d);
		end else if (pick < 14) begin
			plain(rcl_pkg::FUNC_START);
		end else begin
			case ($urandom_range(0, 3))
				0: dep = depth_now;
				1: dep = depth_now + 1;
				2: dep = depth_now - 1;
				default: dep = $urandom;
			endcase
			if (held > 0 && $urandom_range(0, 4) != 0) begin
				r = $urandom_range(0, held - 1);
				position(coord_inside(aim_bn[r], aim_tn[r]), coord_inside(aim_te[r], aim_be[r]),
					dep);
			end else begin
				position(int'($urandom_range(0, 40000)) - 20000,
					int'($urandom_range(0, 40000)) - 20000, dep);
			end
		end
	endtask

	task automatic set_regs(input int lim, input logic per, input logic [15:0] rep);
		write_reg(rcl_pkg::REG_DEPTH, lim);
		write_reg(rcl_pkg::REG_PERIODIC, {31'd0, per});
		write_reg(rcl_pkg::REG_REPUB, {16'd0, rep});
		depth_now = lim;
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = rcl_pkg::FUNC_APPEND;
		cfg_valid = 1'b0;
		cfg_index = rcl_pkg::REG_DEPTH;
		cfg_data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part under reset settings
		now_ms = 100;
		position(0, 0, 0);                     // before start: ignored
		plain(FUNC_NONE);                      // undefined func: ignored
		append(1000, -1000, -1000, 1000, 16'sh7FFF, 16'sh8000, 16'sh1234);
		append(5000, 0, 0, 5000, 16'sh8000, 16'sh7FFF, 16'shFFFF);
		append(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 1, 2, 3);
		plain(rcl_pkg::FUNC_START);
		plain(rcl_pkg::FUNC_START);            // repeated start
		position(0, 0, 0);
		position(500, 500, 128);               // last region kept
		position(3000, 3000, 128);
		position(500, 500, 1000);              // overlap keeps last; too deep to act
		position(1000, 1000, 129);             // inclusive corners of the first region
		position(0, -1000, 0);                 // exclusive east bound of the first
		position(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
		position(0, 32'sh80000000, 32'sh7FFFFFFF);   // in no region
		now_ms = 150;
		position(0, 32'sh80000000, 0);         // unchanged before republish
		now_ms = 600;
		position(0, 32'sh80000000, 0);         // republish reached
		now_ms = 32'hFFFFFFFF;
		position(-1000, 999, 0);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_regs(32'sh7FFFFFFF, 1'b1, 16'd0);
				1: set_regs(32'sh80000000, 1'b0, 16'hFFFF);
				2: set_regs(int'($urandom_range(0, 4000)) - 2000, 1'b1,
					16'($urandom_range(0, 500)));
				3: begin
					set_regs($urandom, 1'b0, 16'd1);
					now_ms = 32'hFFFF0000;
				end
				4: set_regs(128, 1'b1, 16'd200);
				default: set_regs(0, 1'b0, 16'($urandom_range(0, 300)));
			endcase
			if (ph == 2) hold_ask++;
			for (int k = 0; k < PHASE_ITEMS; k++) random_item();
			settle();
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ----- region_current_lookup_unit.f -----
+incdir+rtl
rtl/rcl_pkg.sv
rtl/rcl_ram.sv
rtl/rcl_datapath.sv
rtl/rcl_ctrl.sv
rtl/region_current_lookup_unit.sv
tb/region_current_lookup_checker.sv
tb/region_current_lookup_unit_test.sv
